/* rtl/positional_list_engine_unit_defines.svh */
// Assertion macros used by the checker file.
`ifndef POSITIONAL_LIST_ENGINE_UNIT_DEFINES_SVH
`define POSITIONAL_LIST_ENGINE_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, quiet during reset.
`define PLEU_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("positional list engine check failed");

// Next-cycle implication, sampled on clk_i, quiet during reset.
`define PLEU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("positional list engine check failed");

`endif

/* rtl/pleu_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package pleu_pkg;

  localparam int unsigned AddrMaxW = 6;

  localparam logic [2:0] FnInsHead = 3'd0;
  localparam logic [2:0] FnInsTail = 3'd1;
  localparam logic [2:0] FnInsPos  = 3'd2;
  localparam logic [2:0] FnDelHead = 3'd3;
  localparam logic [2:0] FnDelTail = 3'd4;
  localparam logic [2:0] FnDelPos  = 3'd5;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2,
    ST_EMPTY  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_WR,
    S_DEL_RD,
    S_DEL_WR,
    S_OUT_RD,
    S_OUT_LD,
    S_OUT_EMPTY
  } ctrl_state_e;

  typedef struct packed {
    logic [2:0]         func;
    logic [6:0]         position;
    logic signed [31:0] new_value;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] element;
    logic [5:0]         element_index;
    logic [6:0]         list_length;
    logic               no_elements;
    logic               last_of_run;
  } out_beat_t;

  typedef struct packed {
    logic                we;
    logic [AddrMaxW-1:0] waddr;
    logic signed [31:0]  wdata;
    logic                re;
    logic [AddrMaxW-1:0] raddr;
  } mem_req_t;

endpackage
`default_nettype wire

/* rtl/pleu_mem.sv */
`timescale 1ns / 1ps
`default_nettype none
module pleu_mem #(
  parameter int unsigned DEPTH = 32
) (
  input  wire logic               clk_i,
  input  wire pleu_pkg::mem_req_t req_i,
  output logic signed [31:0]      rdata_o
);
  import pleu_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic signed [31:0] mem_q [DEPTH];
  logic signed [31:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr[AW-1:0]] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr[AW-1:0]];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

/* rtl/pleu_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
module pleu_ctrl #(
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire pleu_pkg::in_beat_t  in_beat_i,
  input  wire logic                slot_free_i,
  output logic                     res_load_o,
  output pleu_pkg::out_beat_t      res_o,
  output pleu_pkg::mem_req_t       mem_req_o,
  input  wire logic signed [31:0]  mem_rdata_i
);
  import pleu_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  ctrl_state_e        state_q, state_d;
  logic [CW-1:0]      count_q, count_d;
  logic [AW-1:0]      idx_q, idx_d;
  logic [AW-1:0]      i_q, i_d;
  logic signed [31:0] val_q, val_d;
  logic [1:0]         status_q, status_d;

  logic          pos_ok;
  logic          list_full;
  logic [CW-1:0] i_inc;
  logic [6:0]    pos_m1;

  assign pos_ok    = (in_beat_i.position >= 7'd2) && (in_beat_i.position <= 7'(count_q));
  assign list_full = (count_q == CW'(DEPTH));
  assign i_inc     = CW'(i_q) + CW'(1);
  assign pos_m1    = in_beat_i.position - 7'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      idx_q    <= '0;
      i_q      <= '0;
      status_q <= ST_DONE;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      idx_q    <= idx_d;
      i_q      <= i_d;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    idx_d      = idx_q;
    i_d        = i_q;
    val_d      = val_q;
    status_d   = status_q;
    in_ready_o = 1'b0;
    res_load_o = 1'b0;
    res_o      = '0;
    mem_req_o  = '0;

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          val_d    = in_beat_i.new_value;
          status_d = ST_DONE;
          i_d      = '0;
          state_d  = (count_q == '0) ? S_OUT_EMPTY : S_OUT_RD;
          unique case (in_beat_i.func) inside
            FnInsHead, FnInsTail, FnInsPos: begin
              if (list_full) begin
                status_d = ST_FULL;
              end else if (in_beat_i.func == FnInsPos && !pos_ok) begin
                status_d = ST_BADPOS;
              end else begin
                i_d     = AW'(count_q);
                state_d = S_INS_RD;
                if (in_beat_i.func == FnInsHead) begin
                  idx_d = '0;
                end else if (in_beat_i.func == FnInsTail) begin
                  idx_d = AW'(count_q);
                end else begin
                  idx_d = AW'(pos_m1);
                end
              end
            end
            FnDelHead, FnDelTail, FnDelPos: begin
              if (count_q == '0) begin
                status_d = ST_EMPTY;
              end else if (in_beat_i.func == FnDelPos && !pos_ok) begin
                status_d = ST_BADPOS;
              end else begin
                state_d = S_DEL_RD;
                if (in_beat_i.func == FnDelHead) begin
                  idx_d = '0;
                  i_d   = '0;
                end else if (in_beat_i.func == FnDelTail) begin
                  idx_d = AW'(count_q - CW'(1));
                  i_d   = AW'(count_q - CW'(1));
                end else begin
                  idx_d = AW'(pos_m1);
                  i_d   = AW'(pos_m1);
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_INS_RD: begin
        if (i_q != idx_q) begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = AddrMaxW'(i_q - AW'(1));
          state_d         = S_INS_WR;
        end else begin
          mem_req_o.we    = 1'b1;
          mem_req_o.waddr = AddrMaxW'(idx_q);
          mem_req_o.wdata = val_q;
          count_d         = count_q + CW'(1);
          i_d             = '0;
          state_d         = S_OUT_RD;
        end
      end
      S_INS_WR: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = AddrMaxW'(i_q);
        mem_req_o.wdata = mem_rdata_i;
        i_d             = i_q - AW'(1);
        state_d         = S_INS_RD;
      end
      S_DEL_RD: begin
        if (i_inc < count_q) begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = AddrMaxW'(i_inc);
          state_d         = S_DEL_WR;
        end else begin
          count_d = count_q - CW'(1);
          i_d     = '0;
          state_d = (count_q == CW'(1)) ? S_OUT_EMPTY : S_OUT_RD;
        end
      end
      S_DEL_WR: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = AddrMaxW'(i_q);
        mem_req_o.wdata = mem_rdata_i;
        i_d             = AW'(i_inc);
        state_d         = S_DEL_RD;
      end
      S_OUT_RD: begin
        if (slot_free_i) begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = AddrMaxW'(i_q);
          state_d         = S_OUT_LD;
        end
      end
      S_OUT_LD: begin
        res_load_o          = 1'b1;
        res_o.status        = status_q;
        res_o.element       = mem_rdata_i;
        res_o.element_index = 6'(i_q);
        res_o.list_length   = 7'(count_q);
        res_o.no_elements   = 1'b0;
        res_o.last_of_run   = (i_inc == count_q);
        if (i_inc == count_q) begin
          state_d = S_IDLE;
        end else begin
          i_d     = AW'(i_inc);
          state_d = S_OUT_RD;
        end
      end
      S_OUT_EMPTY: begin
        if (slot_free_i) begin
          res_load_o        = 1'b1;
          res_o.status      = status_q;
          res_o.no_elements = 1'b1;
          res_o.last_of_run = 1'b1;
          state_d           = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

/* rtl/positional_list_engine_unit.sv */
//  channel | direction | handshake                 | beat
//  --------+-----------+---------------------------+----------------------------
//  in      | input     | in_valid_i / in_ready_o   | pleu_pkg::in_beat_t
//  out     | output    | out_valid_o / out_ready_i | pleu_pkg::out_beat_t
//
//  A beat that changes the list moves M elements one place (a read and a write
//  state each) and writes or drops the entry; every beat then reads out the N
//  elements left (a read and a load state each), or one empty beat if none are
//  left. One element memory, registered read data; input is ready only in idle.
//  Reset clears the element count; memory contents need no clearing.
//  A stalled result holds in the output register and pauses the readout.
`timescale 1ns / 1ps
`default_nettype none
module positional_list_engine_unit #(
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire pleu_pkg::in_beat_t  in_beat_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output pleu_pkg::out_beat_t      out_beat_o
);
  import pleu_pkg::*;

  mem_req_t           mem_req;
  logic signed [31:0] mem_rdata;
  logic               res_load;
  out_beat_t          res;
  logic               slot_free;
  logic               out_valid_q;
  out_beat_t          out_beat_q;

  assign slot_free = !out_valid_q || out_ready_i;

  pleu_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_beat_i  (in_beat_i),
    .slot_free_i(slot_free),
    .res_load_o (res_load),
    .res_o      (res),
    .mem_req_o  (mem_req),
    .mem_rdata_i(mem_rdata)
  );

  pleu_mem #(
    .DEPTH(DEPTH)
  ) u_mem (
    .clk_i  (clk_i),
    .req_i  (mem_req),
    .rdata_o(mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_beat_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_beat_q;

endmodule
`default_nettype wire

/* rtl/pleu_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "positional_list_engine_unit_defines.svh"
module pleu_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_ready_o,
  input wire logic                out_valid_o,
  input wire logic                out_ready_i,
  input wire pleu_pkg::out_beat_t out_beat_o
);
  import pleu_pkg::*;

  `PLEU_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o)

  `PLEU_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_beat_o))

  `PLEU_ASSERT_NOW(a_empty_beat, out_valid_o && out_beat_o.no_elements, out_beat_o.last_of_run && (out_beat_o.list_length == 7'd0) && (out_beat_o.element_index == 6'd0))

  `PLEU_ASSERT_NOW(a_index_range, out_valid_o && !out_beat_o.no_elements, {1'b0, out_beat_o.element_index} < out_beat_o.list_length)

  `PLEU_ASSERT_NOW(a_last_index, out_valid_o && !out_beat_o.no_elements && out_beat_o.last_of_run, ({1'b0, out_beat_o.element_index} + 7'd1) == out_beat_o.list_length)

endmodule

bind positional_list_engine_unit pleu_checker u_pleu_checker (.*);
`default_nettype wire

/* bench/positional_list_engine_unit_tb.sv */
`timescale 1ns / 1ps
module positional_list_engine_unit_tb;
  import pleu_pkg::*;

  localparam int ListDepth = 32;
  localparam int RandomItems = 335;
  localparam int CalmItems = 60;
  localparam int HoldOffAt = 150;
  localparam int HoldOffCycles = 400;
  localparam int QuietLimit = 5000;
  localparam int DrainCycles = 200;
  localparam logic [2:0] FnSpare6 = 3'd6;
  localparam logic [2:0] FnSpare7 = 3'd7;

  typedef struct {
    in_beat_t beat;
    bit       typed;
    status_e  want;
  } plan_row_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_beat_t  in_beat_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_beat_t out_beat_o;

  logic signed [31:0] shadow_list[$];
  out_beat_t          awaited_beats[$];
  bit                 failed = 1'b0;
  bit                 calm = 1'b0;
  bit                 hold_off_req = 1'b0;
  bit                 filling = 1'b1;
  int                 quiet_cycles = 0;

  plan_row_t plan[25] = '{
    '{'{FnDelHead, 7'd0,   32'sh0000_0000}, 1'b1, ST_EMPTY},
    '{'{FnDelTail, 7'd0,   32'sh0000_0000}, 1'b1, ST_EMPTY},
    '{'{FnDelPos,  7'd0,   32'sh0000_0000}, 1'b1, ST_EMPTY},
    '{'{FnDelPos,  7'd127, 32'sh0000_0000}, 1'b1, ST_EMPTY},
    '{'{FnInsPos,  7'd1,   32'sh1234_5678}, 1'b1, ST_BADPOS},
    '{'{FnInsPos,  7'd2,   32'sh1234_5678}, 1'b1, ST_BADPOS},
    '{'{FnSpare6,  7'd0,   32'sh0000_0000}, 1'b1, ST_DONE},
    '{'{FnSpare7,  7'd127, 32'shFFFF_FFFF}, 1'b1, ST_DONE},
    '{'{FnInsHead, 7'd0,   32'sh7FFF_FFFF}, 1'b0, ST_DONE},
    '{'{FnInsTail, 7'd0,   32'sh8000_0000}, 1'b0, ST_DONE},
    '{'{FnInsPos,  7'd2,   32'sh0000_0000}, 1'b0, ST_DONE},
    '{'{FnInsPos,  7'd1,   32'sh0000_0055}, 1'b0, ST_DONE},
    '{'{FnInsPos,  7'd4,   32'sh0000_0066}, 1'b0, ST_DONE},
    '{'{FnInsPos,  7'd3,   32'shFFFF_FFFF}, 1'b0, ST_DONE},
    '{'{FnInsPos,  7'd127, 32'sh0000_0077}, 1'b0, ST_DONE},
    '{'{FnDelPos,  7'd1,   32'sh0000_0000}, 1'b0, ST_DONE},
    '{'{FnDelPos,  7'd5,   32'sh0000_0000}, 1'b0, ST_DONE},
    '{'{FnDelPos,  7'd4,   32'sh0000_0000}, 1'b0, ST_DONE},
    '{'{FnDelPos,  7'd2,   32'sh0000_0000}, 1'b0, ST_DONE},
    '{'{FnDelTail, 7'd0,   32'sh0000_0000}, 1'b0, ST_DONE},
    '{'{FnDelTail, 7'd0,   32'sh0000_0000}, 1'b1, ST_DONE},
    '{'{FnInsTail, 7'd0,   32'sh5A5A_5A5A}, 1'b0, ST_DONE},
    '{'{FnDelHead, 7'd0,   32'sh0000_0000}, 1'b1, ST_DONE},
    '{'{FnInsHead, 7'd0,   32'sh0000_0001}, 1'b0, ST_DONE},
    '{'{FnSpare6,  7'd64,  32'sh0000_0000}, 1'b0, ST_DONE}
  };

  positional_list_engine_unit #(
    .DEPTH(ListDepth)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_beat_i  (in_beat_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_beat_o (out_beat_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic status_e apply_list_op(input in_beat_t b);
    int  n;
    int  p;
    bit  pos_ok;
    status_e st;
    n = shadow_list.size();
    p = b.position;
    pos_ok = (p >= 2) && (p <= n);
    st = ST_DONE;
    case (b.func) inside
      FnInsHead, FnInsTail, FnInsPos: begin
        if (n >= ListDepth) st = ST_FULL;
        else if (b.func == FnInsPos && !pos_ok) st = ST_BADPOS;
        else if (b.func == FnInsHead) shadow_list.push_front(b.new_value);
        else if (b.func == FnInsTail) shadow_list.push_back(b.new_value);
        else shadow_list.insert(p - 1, b.new_value);
      end
      FnDelHead, FnDelTail, FnDelPos: begin
        if (n == 0) st = ST_EMPTY;
        else if (b.func == FnDelPos && !pos_ok) st = ST_BADPOS;
        else if (b.func == FnDelHead) shadow_list.delete(0);
        else if (b.func == FnDelTail) shadow_list.delete(n - 1);
        else shadow_list.delete(p - 1);
      end
      default: st = ST_DONE;
    endcase
    return st;
  endfunction

  function automatic in_beat_t pick_list_op();
    in_beat_t b;
    int n;
    int r;
    n = shadow_list.size();
    if (n == ListDepth && $urandom_range(0, 2) == 0) filling = 1'b0;
    if (n == 0 && $urandom_range(0, 2) == 0) filling = 1'b1;
    if ($urandom_range(0, 39) == 0) filling = !filling;
    b.new_value = $urandom;
    r = $urandom_range(0, 19);
    if (r == 0) begin
      b.func = $urandom_range(0, 1) ? FnSpare6 : FnSpare7;
    end else if ((r <= 14) == filling) begin
      case ($urandom_range(0, 2))
        0: b.func = FnInsHead;
        1: b.func = FnInsTail;
        default: b.func = FnInsPos;
      endcase
    end else begin
      case ($urandom_range(0, 2))
        0: b.func = FnDelHead;
        1: b.func = FnDelTail;
        default: b.func = FnDelPos;
      endcase
    end
    if (n >= 2 && $urandom_range(0, 9) < 7) begin
      b.position = 7'($urandom_range(2, n));
    end else begin
      case ($urandom_range(0, 3))
        0: b.position = 7'd0;
        1: b.position = 7'd1;
        2: b.position = 7'(n + 1);
        default: b.position = 7'($urandom_range(0, 127));
      endcase
    end
    return b;
  endfunction

  task automatic offer(input in_beat_t b, input bit typed, input status_e want);
    status_e   st;
    out_beat_t e;
    int        n;
    in_valid_i <= 1'b1;
    in_beat_i  <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    st = apply_list_op(b);
    n = shadow_list.size();
    if (typed || n == 0) begin
      e = '0;
      e.status = typed ? want : st;
      e.no_elements = 1'b1;
      e.last_of_run = 1'b1;
      awaited_beats.push_back(e);
    end else begin
      for (int k = 0; k < n; k++) begin
        e.status        = st;
        e.element       = shadow_list[k];
        e.element_index = 6'(k);
        e.list_length   = 7'(n);
        e.no_elements   = 1'b0;
        e.last_of_run   = (k == n - 1);
        awaited_beats.push_back(e);
      end
    end
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      failed = 1'b1;
    end
  endtask

  initial begin : result_side
    int        stall_left;
    out_beat_t got;
    out_beat_t want;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        got = out_beat_o;
        if (awaited_beats.size() == 0) begin
          $error("unexpected beat: element %0h index %0d", got.element, got.element_index);
          failed = 1'b1;
        end else begin
          want = awaited_beats.pop_front();
          check_field("status", 32'(want.status), 32'(got.status));
          check_field("element", want.element, got.element);
          check_field("element_index", 32'(want.element_index), 32'(got.element_index));
          check_field("list_length", 32'(want.list_length), 32'(got.list_length));
          check_field("no_elements", 32'(want.no_elements), 32'(got.no_elements));
          check_field("last_of_run", 32'(want.last_of_run), 32'(got.last_of_run));
        end
      end
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall_left = HoldOffCycles;
      end else if (calm) begin
        stall_left = 0;
      end else if (stall_left == 0 && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 8);
      end
      if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    while (quiet_cycles < QuietLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (plan[i]) offer(plan[i].beat, plan[i].typed, plan[i].want);
    for (int i = 0; i < RandomItems; i++) begin
      if (i == HoldOffAt) hold_off_req = 1'b1;
      if (i == RandomItems - CalmItems) calm = 1'b1;
      offer(pick_list_op(), 1'b0, ST_DONE);
    end
    in_valid_i <= 1'b0;
    while (awaited_beats.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (!failed) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
